[rtl/core/bdq_pkg.sv]
// Shared types and constants for the bounded double-ended queue with search.
`default_nettype none

package bdq_pkg;

  // Default number of entries in the ring store.
  localparam int unsigned DEFAULT_DEPTH = 16;

  // Fixed port widths of one request beat and one result beat.
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  // Request codes.
  typedef logic [ACTION_W-1:0] action_t;
  localparam action_t ACT_PUSH_FRONT = 3'd0;
  localparam action_t ACT_PUSH_BACK  = 3'd1;
  localparam action_t ACT_POP_FRONT  = 3'd2;
  localparam action_t ACT_POP_BACK   = 3'd3;
  localparam action_t ACT_READ_INDEX = 3'd4;
  localparam action_t ACT_SEARCH     = 3'd5;

  // Result status codes.
  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_EMPTY    = 2'd1;
  localparam status_t ST_FULL     = 2'd2;
  localparam status_t ST_BAD_POS  = 2'd3;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SEARCH,
    S_RESULT
  } state_t;

endpackage

`default_nettype wire

[rtl/core/bounded_deque_with_search.sv]
// Bounded double-ended queue held in a ring memory, with a sequential search.
// Pushes, rejected requests and unused codes go from accept straight to the result state; pops and
// reads pass through a read state first, because the element memory has a registered read port.
// A search reads one live entry per cycle and moves to the result state on a hit or after the last
// live entry is compared; a search of an empty queue goes straight to the result state.
// One request is in work at a time; a new one is taken once the last has left the result state.
// A finished result waits in the output register while the next request is accepted, and a held
// result stalls the following one. Active-low synchronous reset empties the queue, not the memory.
`default_nettype none

module bounded_deque_with_search #(
  parameter int unsigned DEPTH = bdq_pkg::DEFAULT_DEPTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Request channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [bdq_pkg::ACTION_W-1:0]      in_action,
  input  wire logic signed [bdq_pkg::VALUE_W-1:0] in_value,
  input  wire logic [bdq_pkg::POS_W-1:0]         in_position,
  // Result channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [bdq_pkg::VALUE_W-1:0]     out_data_out,
  output logic                                   out_found,
  output logic [bdq_pkg::STATUS_W-1:0]           out_status,
  output logic [bdq_pkg::COUNT_W-1:0]            out_count_out
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;
  localparam int unsigned CMP_W = (CNT_W > bdq_pkg::POS_W) ? CNT_W : bdq_pkg::POS_W;
  localparam int unsigned VW    = bdq_pkg::VALUE_W;

  // Ring position of the entry at a given offset from the front.
  function automatic logic [PTR_W-1:0] slot_at(input logic [PTR_W-1:0] front,
                                               input logic [CNT_W-1:0] offset);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(front) + SUM_W'(offset);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  // Element memory with a synchronous, registered read port.
  logic [VW-1:0]    mem [DEPTH];
  logic             wr_en;
  logic [PTR_W-1:0] wr_addr;
  logic [VW-1:0]    wr_data;
  logic             rd_en;
  logic [PTR_W-1:0] rd_addr;
  logic [VW-1:0]    rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Control and payload registers.
  bdq_pkg::state_t     state_r, state_nxt;
  logic [PTR_W-1:0]    front_r, front_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    scan_r, scan_nxt;
  logic [VW-1:0]       key_r, key_nxt;
  logic [VW-1:0]       res_data_r, res_data_nxt;
  logic                res_found_r, res_found_nxt;
  bdq_pkg::status_t    res_status_r, res_status_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [VW-1:0]       out_data_r, out_data_nxt;
  logic                out_found_r, out_found_nxt;
  bdq_pkg::status_t    out_status_r, out_status_nxt;
  logic [CNT_W-1:0]    out_count_r, out_count_nxt;

  logic                accept;
  logic                is_full;
  logic                is_empty;
  logic [PTR_W-1:0]    front_dec;
  logic [PTR_W-1:0]    front_inc;
  logic [CMP_W-1:0]    pos_ext;
  logic [CMP_W-1:0]    cnt_ext;
  logic                out_free;

  assign in_stall = (state_r != bdq_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign is_full  = (count_r >= CNT_W'(DEPTH));
  assign is_empty = (count_r == '0);
  assign front_dec = (front_r == '0) ? PTR_W'(DEPTH - 1) : front_r - PTR_W'(1);
  assign front_inc = (front_r == PTR_W'(DEPTH - 1)) ? '0 : front_r + PTR_W'(1);
  assign pos_ext  = CMP_W'(in_position);
  assign cnt_ext  = CMP_W'(count_r);
  assign out_free = !out_valid_r || !out_stall;

  // Sequencer: decode on accept, wait for memory data, scan for a search, then hand over.
  always_comb begin
    state_nxt      = state_r;
    front_nxt      = front_r;
    count_nxt      = count_r;
    scan_nxt       = scan_r;
    key_nxt        = key_r;
    res_data_nxt   = res_data_r;
    res_found_nxt  = res_found_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    out_found_nxt  = out_found_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    wr_en          = 1'b0;
    wr_addr        = front_r;
    wr_data        = in_value;
    rd_en          = 1'b0;
    rd_addr        = front_r;

    unique case (state_r)
      bdq_pkg::S_IDLE: begin
        if (accept) begin
          res_data_nxt   = '0;
          res_found_nxt  = 1'b0;
          res_status_nxt = bdq_pkg::ST_OK;
          key_nxt        = in_value;
          scan_nxt       = '0;
          state_nxt      = bdq_pkg::S_RESULT;
          unique case (in_action)
            bdq_pkg::ACT_PUSH_FRONT: begin
              if (is_full) begin
                res_status_nxt = bdq_pkg::ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = front_dec;
                front_nxt = front_dec;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            bdq_pkg::ACT_PUSH_BACK: begin
              if (is_full) begin
                res_status_nxt = bdq_pkg::ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = slot_at(front_r, count_r);
                count_nxt = count_r + CNT_W'(1);
              end
            end
            bdq_pkg::ACT_POP_FRONT: begin
              if (is_empty) begin
                res_status_nxt = bdq_pkg::ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = front_r;
                front_nxt = front_inc;
                count_nxt = count_r - CNT_W'(1);
                state_nxt = bdq_pkg::S_READ;
              end
            end
            bdq_pkg::ACT_POP_BACK: begin
              if (is_empty) begin
                res_status_nxt = bdq_pkg::ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = slot_at(front_r, count_r - CNT_W'(1));
                count_nxt = count_r - CNT_W'(1);
                state_nxt = bdq_pkg::S_READ;
              end
            end
            bdq_pkg::ACT_READ_INDEX: begin
              if (is_empty) begin
                res_status_nxt = bdq_pkg::ST_EMPTY;
              end else if (pos_ext >= cnt_ext) begin
                res_status_nxt = bdq_pkg::ST_BAD_POS;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = slot_at(front_r, CNT_W'(in_position));
                state_nxt = bdq_pkg::S_READ;
              end
            end
            bdq_pkg::ACT_SEARCH: begin
              // An empty queue finds nothing; otherwise start reading from the front.
              if (!is_empty) begin
                rd_en     = 1'b1;
                rd_addr   = front_r;
                state_nxt = bdq_pkg::S_SEARCH;
              end
            end
            default: begin
            end
          endcase
        end
      end

      bdq_pkg::S_READ: begin
        res_data_nxt = rd_data_r;
        state_nxt    = bdq_pkg::S_RESULT;
      end

      bdq_pkg::S_SEARCH: begin
        // The entry at offset scan_r is on the read port this cycle.
        if (rd_data_r == key_r) begin
          res_found_nxt = 1'b1;
          state_nxt     = bdq_pkg::S_RESULT;
        end else if (scan_r == count_r - CNT_W'(1)) begin
          state_nxt = bdq_pkg::S_RESULT;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = slot_at(front_r, scan_r + CNT_W'(1));
          scan_nxt = scan_r + CNT_W'(1);
        end
      end

      bdq_pkg::S_RESULT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = res_data_r;
          out_found_nxt  = res_found_r;
          out_status_nxt = res_status_r;
          out_count_nxt  = count_r;
          state_nxt      = bdq_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = bdq_pkg::S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bdq_pkg::S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    scan_r       <= scan_nxt;
    key_r        <= key_nxt;
    res_data_r   <= res_data_nxt;
    res_found_r  <= res_found_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
    out_found_r  <= out_found_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  // Result beat.
  assign out_valid     = out_valid_r;
  assign out_data_out  = out_data_r;
  assign out_found     = out_found_r;
  assign out_status    = out_status_r;
  assign out_count_out = bdq_pkg::COUNT_W'(out_count_r);

endmodule

`default_nettype wire

[bench/bounded_deque_with_search_test.sv]
// Self-checking testbench for the bounded double-ended queue with search.
`default_nettype none

module bounded_deque_with_search_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = bdq_pkg::DEFAULT_DEPTH;

  // The two request codes that the queue does not serve.
  localparam bdq_pkg::action_t ACT_SPARE_A = 3'd6;
  localparam bdq_pkg::action_t ACT_SPARE_B = 3'd7;

  localparam logic signed [bdq_pkg::VALUE_W-1:0] VALUE_MAX =
    {1'b0, {(bdq_pkg::VALUE_W-1){1'b1}}};
  localparam logic signed [bdq_pkg::VALUE_W-1:0] VALUE_MIN =
    {1'b1, {(bdq_pkg::VALUE_W-1){1'b0}}};

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
  localparam int HOLD_CYCLES  = 120;

  // One result beat as the queue should report it.
  typedef struct packed {
    logic signed [bdq_pkg::VALUE_W-1:0] data;
    logic                               found;
    bdq_pkg::status_t                   status;
    logic [bdq_pkg::COUNT_W-1:0]        count;
  } deque_result_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                               in_valid    = 1'b0;
  logic                               in_stall;
  bdq_pkg::action_t                   in_action   = bdq_pkg::ACT_PUSH_FRONT;
  logic signed [bdq_pkg::VALUE_W-1:0] in_value    = '0;
  logic [bdq_pkg::POS_W-1:0]          in_position = '0;

  logic                               out_valid;
  logic                               out_stall   = 1'b0;
  logic signed [bdq_pkg::VALUE_W-1:0] out_data_out;
  logic                               out_found;
  logic [bdq_pkg::STATUS_W-1:0]       out_status;
  logic [bdq_pkg::COUNT_W-1:0]        out_count_out;

  // Shadow copy of the queue contents, updated as each request beat is accepted.
  logic signed [bdq_pkg::VALUE_W-1:0] shadow_store [DEPTH];
  int shadow_front = 0;
  int shadow_count = 0;

  deque_result_t expected_results [$];

  int  send_gap_max = 8;
  int  recv_gap_max = 8;
  bit  out_hold     = 1'b0;
  bit  fill_up      = 1'b1;

  int  cycle_count        = 0;
  int  input_stall_cycles = 0;
  int  result_beats       = 0;
  int  results_paced      = 0;
  int  recv_wait          = 0;
  int  mismatches         = 0;
  int  requests_by_action [8];
  int  search_hits        = 0;
  int  full_refusals      = 0;
  int  empty_refusals     = 0;
  int  position_refusals  = 0;

  bounded_deque_with_search #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_value     (in_value),
    .in_position  (in_position),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data_out (out_data_out),
    .out_found    (out_found),
    .out_status   (out_status),
    .out_count_out(out_count_out)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Cycle budget, and a tally of cycles in which the queue refuses a request beat.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (in_valid && in_stall) begin
      input_stall_cycles <= input_stall_cycles + 1;
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles without finishing.", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Index into the ring store of the element at a given offset from the front.
  function automatic int slot_of(int offset);
    return (shadow_front + offset) % DEPTH;
  endfunction

  // Applies one request to the shadow queue and returns the result it should give.
  function automatic deque_result_t predict_deque_result(
    bdq_pkg::action_t act,
    logic signed [bdq_pkg::VALUE_W-1:0] val,
    logic [bdq_pkg::POS_W-1:0] pos);
    deque_result_t r;
    int i;
    r = '0;
    case (act)
      bdq_pkg::ACT_PUSH_FRONT: begin
        if (shadow_count >= DEPTH) begin
          r.status = bdq_pkg::ST_FULL;
        end else begin
          shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
          shadow_store[shadow_front] = val;
          shadow_count++;
        end
      end
      bdq_pkg::ACT_PUSH_BACK: begin
        if (shadow_count >= DEPTH) begin
          r.status = bdq_pkg::ST_FULL;
        end else begin
          shadow_store[slot_of(shadow_count)] = val;
          shadow_count++;
        end
      end
      bdq_pkg::ACT_POP_FRONT: begin
        if (shadow_count == 0) begin
          r.status = bdq_pkg::ST_EMPTY;
        end else begin
          r.data = shadow_store[shadow_front];
          shadow_front = (shadow_front + 1) % DEPTH;
          shadow_count--;
        end
      end
      bdq_pkg::ACT_POP_BACK: begin
        if (shadow_count == 0) begin
          r.status = bdq_pkg::ST_EMPTY;
        end else begin
          r.data = shadow_store[slot_of(shadow_count - 1)];
          shadow_count--;
        end
      end
      bdq_pkg::ACT_READ_INDEX: begin
        if (shadow_count == 0) begin
          r.status = bdq_pkg::ST_EMPTY;
        end else if (int'(pos) >= shadow_count) begin
          r.status = bdq_pkg::ST_BAD_POS;
        end else begin
          r.data = shadow_store[slot_of(int'(pos))];
        end
      end
      bdq_pkg::ACT_SEARCH: begin
        for (i = 0; i < shadow_count; i++) begin
          if (shadow_store[slot_of(i)] == val) begin
            r.found = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    r.count = bdq_pkg::COUNT_W'(shadow_count);
    return r;
  endfunction

  // Offers one request beat after a random gap and waits until the queue takes it.
  task automatic send_request(bdq_pkg::action_t act,
                              logic signed [bdq_pkg::VALUE_W-1:0] val,
                              logic [bdq_pkg::POS_W-1:0] pos);
    int gap;
    deque_result_t r;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_action   <= act;
    in_value    <= val;
    in_position <= pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = predict_deque_result(act, val, pos);
    expected_results.push_back(r);
    requests_by_action[act]++;
    if (r.found) search_hits++;
    if (r.status == bdq_pkg::ST_FULL) full_refusals++;
    if (r.status == bdq_pkg::ST_EMPTY) empty_refusals++;
    if (r.status == bdq_pkg::ST_BAD_POS) position_refusals++;
    @(negedge clk);
  endtask

  // Random bit patterns half the time, with the extremes and a few small values mixed in.
  function automatic logic signed [bdq_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return VALUE_MAX;
      1:       return VALUE_MIN;
      2, 3:    return int'($urandom_range(0, 6)) - 3;
      default: return $urandom();
    endcase
  endfunction

  // Draws one request, leaning towards filling or draining the queue in long runs.
  task automatic send_random_request(output bit served);
    bdq_pkg::action_t act;
    logic signed [bdq_pkg::VALUE_W-1:0] val;
    logic [bdq_pkg::POS_W-1:0] pos;
    int roll;
    int push_share;
    int pop_share;
    if (shadow_count == DEPTH && $urandom_range(0, 3) == 0) fill_up = 1'b0;
    if (shadow_count == 0 && $urandom_range(0, 3) == 0) fill_up = 1'b1;
    push_share = fill_up ? 45 : 15;
    pop_share  = fill_up ? 15 : 45;
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      act = roll[0] ? ACT_SPARE_B : ACT_SPARE_A;
    end else if (roll < 3 + push_share) begin
      act = roll[0] ? bdq_pkg::ACT_PUSH_BACK : bdq_pkg::ACT_PUSH_FRONT;
    end else if (roll < 3 + push_share + pop_share) begin
      act = roll[0] ? bdq_pkg::ACT_POP_BACK : bdq_pkg::ACT_POP_FRONT;
    end else if (roll < 23 + push_share + pop_share) begin
      act = bdq_pkg::ACT_READ_INDEX;
    end else begin
      act = bdq_pkg::ACT_SEARCH;
    end
    // Searches usually look for a value that is present somewhere in the queue.
    if (act == bdq_pkg::ACT_SEARCH && shadow_count > 0 && $urandom_range(0, 9) < 6) begin
      val = shadow_store[slot_of($urandom_range(0, shadow_count - 1))];
    end else begin
      val = pick_value();
    end
    if (shadow_count > 0 && $urandom_range(0, 3) != 0) begin
      pos = bdq_pkg::POS_W'($urandom_range(0, shadow_count - 1));
    end else begin
      pos = bdq_pkg::POS_W'($urandom_range(0, (1 << bdq_pkg::POS_W) - 1));
    end
    send_request(act, val, pos);
    served = (act != ACT_SPARE_A) && (act != ACT_SPARE_B);
  endtask

  // Every request but the pushes on an empty queue, the unused codes among them.
  task automatic test_empty_queue_requests();
    send_request(bdq_pkg::ACT_POP_FRONT, 32'sd5, '0);
    send_request(bdq_pkg::ACT_POP_BACK, 32'sd6, '1);
    send_request(bdq_pkg::ACT_READ_INDEX, 32'sd0, '0);
    send_request(bdq_pkg::ACT_SEARCH, 32'sd0, '0);
    send_request(ACT_SPARE_A, VALUE_MAX, '1);
    send_request(ACT_SPARE_B, VALUE_MIN, '0);
  endtask

  // Extreme values at both ends, reads at the edges of the live range, hits and misses.
  task automatic test_directed_contents();
    send_request(bdq_pkg::ACT_PUSH_FRONT, VALUE_MAX, '0);
    send_request(bdq_pkg::ACT_PUSH_BACK, VALUE_MIN, '0);
    send_request(bdq_pkg::ACT_PUSH_FRONT, 32'sd0, '0);
    send_request(bdq_pkg::ACT_PUSH_BACK, -32'sd1, '0);
    send_request(bdq_pkg::ACT_READ_INDEX, 32'sd0, 4'd0);
    send_request(bdq_pkg::ACT_READ_INDEX, 32'sd0, 4'd3);
    send_request(bdq_pkg::ACT_READ_INDEX, 32'sd0, 4'd4);
    send_request(bdq_pkg::ACT_READ_INDEX, 32'sd0, 4'd15);
    send_request(bdq_pkg::ACT_SEARCH, -32'sd1, '0);
    send_request(bdq_pkg::ACT_SEARCH, 32'sd1, '0);
    send_request(bdq_pkg::ACT_SEARCH, VALUE_MIN, '0);
    send_request(bdq_pkg::ACT_POP_FRONT, 32'sd0, '0);
    send_request(bdq_pkg::ACT_POP_BACK, 32'sd0, '0);
    send_request(bdq_pkg::ACT_POP_FRONT, 32'sd0, '0);
    send_request(bdq_pkg::ACT_POP_BACK, 32'sd0, '0);
  endtask

  // Fills the queue to the brim, pushes past it, probes it and empties it again.
  task automatic test_full_and_wrap(int rounds);
    repeat (rounds) begin
      while (shadow_count < DEPTH) begin
        send_request($urandom_range(0, 1) ? bdq_pkg::ACT_PUSH_BACK : bdq_pkg::ACT_PUSH_FRONT,
                     pick_value(), '0);
      end
      send_request(bdq_pkg::ACT_PUSH_FRONT, pick_value(), '0);
      send_request(bdq_pkg::ACT_PUSH_BACK, pick_value(), '0);
      send_request(bdq_pkg::ACT_READ_INDEX, 32'sd0, 4'd15);
      send_request(bdq_pkg::ACT_READ_INDEX, 32'sd0,
                   bdq_pkg::POS_W'($urandom_range(0, DEPTH - 1)));
      send_request(bdq_pkg::ACT_SEARCH, shadow_store[slot_of(DEPTH - 1)], '0);
      while (shadow_count > 0) begin
        send_request($urandom_range(0, 1) ? bdq_pkg::ACT_POP_BACK : bdq_pkg::ACT_POP_FRONT,
                     32'sd0, '0);
      end
      send_request(bdq_pkg::ACT_POP_FRONT, 32'sd0, '0);
    end
  endtask

  // A stretch of random traffic with the given gap limits on each side.
  task automatic test_random_traffic(int n_items, int send_max, int recv_max);
    int served_items;
    bit served;
    send_gap_max = send_max;
    recv_gap_max = recv_max;
    served_items = 0;
    while (served_items < n_items) begin
      send_random_request(served);
      if (served) served_items++;
    end
  endtask

  // The receiver refuses results for a long stretch while requests keep coming.
  task automatic test_output_backpressure(int n_items);
    send_gap_max = 0;
    fork
      begin
        @(posedge clk);
        out_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_hold = 1'b0;
      end
      begin
        bit served;
        repeat (n_items) send_random_request(served);
      end
    join
  endtask

  // Receiver pacing: after each result beat taken, stall for a randomly drawn while.
  always @(negedge clk) begin
    if (result_beats != results_paced) begin
      results_paced = result_beats;
      recv_wait = $urandom_range(0, recv_gap_max);
    end
    out_stall <= out_hold || (recv_wait != 0);
    if (recv_wait != 0) recv_wait--;
  end

  // Each result beat is compared field by field with the oldest expectation.
  always @(posedge clk) begin : result_check
    deque_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      result_beats++;
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: data_out %0d, status %0d",
               out_data_out, out_status);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (out_data_out !== want.data) begin
          $error("data_out: expected %0d, got %0d", want.data, out_data_out);
          mismatches++;
        end
        if (out_found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_found);
          mismatches++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          mismatches++;
        end
        if (out_count_out !== want.count) begin
          $error("count_out: expected %0d, got %0d", want.count, out_count_out);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_queue_requests();
    test_directed_contents();
    test_full_and_wrap(3);
    test_random_traffic(500, 8, 8);
    test_random_traffic(300, 0, 0);
    test_output_backpressure(40);
    test_random_traffic(300, 0, 8);
    test_random_traffic(300, 8, 0);

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d result beats: %0d pushes, %0d pops, %0d reads, %0d searches (%0d hits).",
             result_beats,
             requests_by_action[bdq_pkg::ACT_PUSH_FRONT] +
             requests_by_action[bdq_pkg::ACT_PUSH_BACK],
             requests_by_action[bdq_pkg::ACT_POP_FRONT] +
             requests_by_action[bdq_pkg::ACT_POP_BACK],
             requests_by_action[bdq_pkg::ACT_READ_INDEX],
             requests_by_action[bdq_pkg::ACT_SEARCH], search_hits);
    $display("Refused: %0d full, %0d empty, %0d bad position; input held off %0d cycles.",
             full_refusals, empty_refusals, position_refusals, input_stall_cycles);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
